// ===== hw/rtl/fvnp_pkg.sv =====
// ----------------------------------------------------------------------------
// fvnp_pkg
// Shared types, constants and elaboration-time table functions for the
// fractal value noise point core.
// ----------------------------------------------------------------------------
`default_nettype none

package fvnp_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_DIM_MODE   = 3'd0;
  localparam logic [2:0] CFG_BASE_AMP   = 3'd1;
  localparam logic [2:0] CFG_INV_SCALE  = 3'd2;
  localparam logic [2:0] CFG_PERSIST    = 3'd3;
  localparam logic [2:0] CFG_OCT_COUNT  = 3'd4;

  // octave index width (covers up to 31 octaves)
  localparam int KW = 5;

  // hash constants
  localparam logic [31:0] HASH_MUL_A  = 32'd15731;
  localparam logic [31:0] HASH_ADD_A  = 32'd789221;
  localparam logic [31:0] HASH_ADD_B  = 32'd1376312589;
  localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
  localparam logic [31:0] HASH_Y_MUL  = 32'd57;
  localparam int          HASH_SHIFT  = 13;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // weight of one in Q1.14
  localparam logic [14:0] W_ONE = 15'd16384;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_SCALE,
    OP_SPLIT,
    OP_WLOOK,
    OP_HPRE,
    OP_HSQ,
    OP_HLIN,
    OP_HFIN,
    OP_BL1,
    OP_BL2,
    OP_ACC1,
    OP_ACC2,
    OP_DINIT,
    OP_DSTEP,
    OP_FIN
  } op_t;

  // command word: operation, operand select, current octave
  typedef struct packed {
    op_t           op;
    logic [1:0]    sel;
    logic [KW-1:0] k;
  } cmd_t;

  // cos(pi*m/2^tb) in Q2.30 via 8-term Taylor series, clamped to [0,1]
  function automatic longint cos_q30(input longint unsigned m, input int tb);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    int              n;
    a    = (64'd3373259426 * m) >> tb;
    a2   = (a * a) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (n = 1; n <= 8; n++) begin
      term = (term * a2) >> 30;
      case (n)
        1:       term = term / 2;
        2:       term = term / 12;
        3:       term = term / 30;
        4:       term = term / 56;
        5:       term = term / 90;
        6:       term = term / 132;
        7:       term = term / 182;
        default: term = term / 240;
      endcase
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
    return sum;
  endfunction

  // (1-cos(pi*i/2^tb))/2 in Q1.14, rounded half up
  function automatic logic [14:0] weight_entry(input int i, input int tb);
    longint tsize;
    longint v;
    tsize = longint'(1) << tb;
    if (longint'(i) <= (tsize >> 1)) v = (64'sd1 << 30) - cos_q30(longint'(i), tb);
    else                             v = (64'sd1 << 30) + cos_q30(tsize - longint'(i), tb);
    return 15'((v + 64'sd65536) >>> 17);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fractal_value_noise_point_core.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_point_core
// Fractal value noise for one coordinate pair: configuration registers,
// sequencer and datapath.
// ----------------------------------------------------------------------------
// One request at a time, for an octave count clamped to MAX_OCTAVES; the next
// request can be taken in the same cycle that out_valid is shown.
// Per octave: scale and split of x (and of y in 2D mode), weight lookup, hash of
// each corner, blends (only the x blend in 1D), accumulate; normalization runs
// the divide steps; receiver cannot stall.
// Synchronous active-low reset idles the sequencer and loads register defaults.
`default_nettype none

module fractal_value_noise_point_core #(
  parameter int MAX_OCTAVES    = 8,
  parameter int COS_TABLE_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  output logic                    out_valid,
  output logic signed [15:0]      out_height,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import fvnp_pkg::*;

  logic        dim_mode_r;
  logic [15:0] base_amp_r;
  logic [31:0] inv_scale_r;
  logic [14:0] persist_r;
  logic [3:0]  oct_count_r;
  cmd_t        cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_mode_r  <= 1'b0;
      base_amp_r  <= 16'd256;
      inv_scale_r <= 32'd16777216;
      persist_r   <= 15'd8192;
      oct_count_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM_MODE:  dim_mode_r  <= cfg_wdata[0];
        CFG_BASE_AMP:  base_amp_r  <= cfg_wdata[15:0];
        CFG_INV_SCALE: inv_scale_r <= cfg_wdata;
        CFG_PERSIST:   persist_r   <= cfg_wdata[14:0];
        CFG_OCT_COUNT: oct_count_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  fvnp_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .dim_mode     (dim_mode_r),
    .octave_count (oct_count_r),
    .busy         (busy),
    .cmd          (cmd)
  );

  fvnp_dp #(
    .MAX_OCTAVES    (MAX_OCTAVES),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .coord_x        (in_coord_x),
    .coord_y        (in_coord_y),
    .dim_mode       (dim_mode_r),
    .base_amplitude (base_amp_r),
    .inverse_scale  (inv_scale_r),
    .persistence    (persist_r),
    .out_valid      (out_valid),
    .out_height     (out_height)
  );

  // a result closes the request
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // accepted request makes the core busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

  // one strobe per request
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result");

  // saturated range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_height <= 16'sd16384 && out_height >= -16'sd16384))
    else $error("height out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/fvnp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fvnp_ctrl
// Sequencer: walks octaves, corners and blends, then the divide steps, and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnp_ctrl #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             dim_mode,
  input  wire logic [3:0]       octave_count,
  output logic                  busy,
  output fvnp_pkg::cmd_t        cmd
);
  import fvnp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCX, S_SPX, S_SCY, S_SPY, S_WL,
    S_HPRE, S_HSQ, S_HLIN, S_HFIN, S_BL1, S_BL2,
    S_ACC1, S_ACC2, S_DINIT, S_DSTEP, S_FIN
  } state_t;

  localparam logic [KW-1:0] MAX_K = KW'(MAX_OCTAVES);

  state_t        state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [3:0]    div_r, div_nxt;
  logic          busy_r, busy_nxt;
  logic [KW-1:0] count;
  logic [1:0]    last_corner, last_blend;

  // effective octave count, clamped to the build limit
  assign count       = ({1'b0, octave_count} > MAX_K) ? MAX_K : KW'(octave_count);
  assign last_corner = dim_mode ? 2'd1 : 2'd3;
  assign last_blend  = dim_mode ? 2'd0 : 2'd2;

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    sub_nxt   = sub_r;
    div_nxt   = div_r;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = (count == '0) ? S_DINIT : S_SCX;
        k_nxt     = KW'(1);
      end
      S_SCX:   state_nxt = S_SPX;
      S_SPX:   state_nxt = dim_mode ? S_WL : S_SCY;
      S_SCY:   state_nxt = S_SPY;
      S_SPY:   state_nxt = S_WL;
      S_WL: begin
        state_nxt = S_HPRE;
        sub_nxt   = 2'd0;
      end
      S_HPRE:  state_nxt = S_HSQ;
      S_HSQ:   state_nxt = S_HLIN;
      S_HLIN:  state_nxt = S_HFIN;
      S_HFIN: begin
        if (sub_r == last_corner) begin
          state_nxt = S_BL1;
          sub_nxt   = 2'd0;
        end else begin
          state_nxt = S_HPRE;
          sub_nxt   = sub_r + 2'd1;
        end
      end
      S_BL1:   state_nxt = S_BL2;
      S_BL2: begin
        if (sub_r == last_blend) begin
          state_nxt = S_ACC1;
        end else begin
          state_nxt = S_BL1;
          sub_nxt   = sub_r + 2'd1;
        end
      end
      S_ACC1:  state_nxt = S_ACC2;
      S_ACC2: begin
        if (k_r >= count) begin
          state_nxt = S_DINIT;
        end else begin
          state_nxt = S_SCX;
          k_nxt     = k_r + KW'(1);
        end
      end
      S_DINIT: begin
        state_nxt = S_DSTEP;
        div_nxt   = 4'd0;
      end
      S_DSTEP: begin
        div_nxt = div_r + 4'd1;
        if (div_r == 4'd15) state_nxt = S_FIN;
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      sub_r   <= '0;
      div_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      sub_r   <= sub_nxt;
      div_r   <= div_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // command decode; the request is captured at the edge that accepts it
  always_comb begin
    cmd.k   = k_r;
    cmd.sel = sub_r;
    case (state_r)
      S_IDLE:  cmd.op = start ? OP_START : OP_NOP;
      S_SCX: begin
        cmd.op  = OP_SCALE;
        cmd.sel = 2'd0;
      end
      S_SPX: begin
        cmd.op  = OP_SPLIT;
        cmd.sel = 2'd0;
      end
      S_SCY: begin
        cmd.op  = OP_SCALE;
        cmd.sel = 2'd1;
      end
      S_SPY: begin
        cmd.op  = OP_SPLIT;
        cmd.sel = 2'd1;
      end
      S_WL:    cmd.op = OP_WLOOK;
      S_HPRE:  cmd.op = OP_HPRE;
      S_HSQ:   cmd.op = OP_HSQ;
      S_HLIN:  cmd.op = OP_HLIN;
      S_HFIN:  cmd.op = OP_HFIN;
      S_BL1:   cmd.op = OP_BL1;
      S_BL2:   cmd.op = OP_BL2;
      S_ACC1:  cmd.op = OP_ACC1;
      S_ACC2:  cmd.op = OP_ACC2;
      S_DINIT: cmd.op = OP_DINIT;
      S_DSTEP: cmd.op = OP_DSTEP;
      S_FIN:   cmd.op = OP_FIN;
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fvnp_dp.sv =====
// ----------------------------------------------------------------------------
// fvnp_dp
// Datapath: coordinate scaling, lattice hash, cosine blend, octave
// accumulation and a radix-2 restoring divider for normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnp_dp #(
  parameter int MAX_OCTAVES    = 8,
  parameter int COS_TABLE_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fvnp_pkg::cmd_t     cmd,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic               dim_mode,
  input  wire logic [15:0]        base_amplitude,
  input  wire logic [31:0]        inverse_scale,
  input  wire logic [14:0]        persistence,
  output logic                    out_valid,
  output logic signed [15:0]      out_height
);
  import fvnp_pkg::*;

  localparam int TB    = COS_TABLE_BITS;
  localparam int TSIZE = 1 << TB;
  localparam int AW    = 23 + MAX_OCTAVES;   // amplitude, Q.16
  localparam int SUMW  = 24 + MAX_OCTAVES;   // amplitude sum
  localparam int TW    = AW + 20;            // amp * octave value
  localparam int ACCW  = SUMW + 20;          // weighted sum
  localparam int DW    = ACCW + 1;           // divider

  // constant weight table
  logic [14:0] wtab [TSIZE];
  for (genvar gi = 0; gi < TSIZE; gi++) begin : g_wtab
    localparam logic [14:0] WVAL = weight_entry(gi, TB);
    assign wtab[gi] = WVAL;
  end

  logic [31:0]           mag_x_r, mag_y_r;
  logic                  neg_x_r, neg_y_r;
  logic [63:0]           prod_r;
  logic [31:0]           cell_x_r, cell_y_r;
  logic [TB-1:0]         idx_x_r, idx_y_r;
  logic [14:0]           wx_r, wy_r;
  logic [31:0]           n_r, t_r;
  logic signed [31:0]    corner_r [4];
  logic signed [47:0]    mul_a_r;
  logic signed [31:0]    blend_r [2];
  logic [AW-1:0]         amp_r;
  logic [SUMW-1:0]       amp_sum_r;
  logic signed [TW-1:0]  term_r;
  logic signed [ACCW-1:0] acc_r;
  logic                  neg_res_r, zero_r;
  logic [DW-1:0]         rem_r, dsh_r;
  logic [15:0]           quo_r;
  logic                  out_valid_r;
  logic signed [15:0]    out_height_r;

  // scale: |c| * inverse_scale
  logic [63:0] sc_mag, sc_inv, sc_prod;
  assign sc_mag  = 64'(cmd.sel[0] ? mag_y_r : mag_x_r);
  assign sc_inv  = 64'(inverse_scale);
  assign sc_prod = sc_mag * sc_inv;

  // split: product times k*k, cell and table index
  logic [2*KW-1:0] k2;
  logic [73:0]     hi_p, lo_p, total;
  logic [31:0]     cell_mag, cell_s;
  logic            sp_neg;
  assign k2       = cmd.k * cmd.k;
  assign hi_p     = 74'(prod_r[63:32]) * 74'(k2);
  assign lo_p     = 74'(prod_r[31:0]) * 74'(k2);
  assign total    = (hi_p << 32) + lo_p;
  assign cell_mag = total[71:40];
  assign sp_neg   = cmd.sel[0] ? neg_y_r : neg_x_r;
  assign cell_s   = sp_neg ? (32'd0 - cell_mag) : cell_mag;

  // hash front: corner address mix
  logic [31:0] hx, hy, hn0, hn;
  assign hx  = cell_x_r + 32'(cmd.sel[0]);
  assign hy  = dim_mode ? 32'd0 : (cell_y_r + 32'(cmd.sel[1]));
  assign hn0 = hx + 32'(hy * HASH_Y_MUL);
  assign hn  = (hn0 << HASH_SHIFT) ^ hn0;

  // hash tail
  logic [31:0]        hv;
  logic signed [31:0] hcorner;
  assign hv      = (32'(n_r * t_r) + HASH_ADD_B) & HASH_MASK;
  assign hcorner = ONE_Q30 - $signed(hv);

  // blend operand select
  logic signed [31:0] bl_a, bl_b;
  logic [14:0]        bl_w;
  always_comb begin
    case (cmd.sel)
      2'd0: begin
        bl_a = corner_r[0];
        bl_b = corner_r[1];
        bl_w = wx_r;
      end
      2'd1: begin
        bl_a = corner_r[2];
        bl_b = corner_r[3];
        bl_w = wx_r;
      end
      default: begin
        bl_a = blend_r[0];
        bl_b = blend_r[1];
        bl_w = wy_r;
      end
    endcase
  end

  logic signed [47:0] bl_a_w, bl_b_w, bl_wi, bl_ww, bl_s, bl_rnd;
  assign bl_a_w = 48'(bl_a);
  assign bl_b_w = 48'(bl_b);
  assign bl_wi  = $signed({33'd0, 15'(W_ONE - bl_w)});
  assign bl_ww  = $signed({33'd0, bl_w});
  assign bl_s   = mul_a_r + bl_b_w * bl_ww;
  assign bl_rnd = bl_s + 48'sd8192;

  // octave value rounded to Q.16, weighted by amplitude
  logic signed [32:0]   ov_rnd;
  logic signed [TW-1:0] ov_r, amp_s;
  assign ov_rnd = 33'(blend_r[0]) + 33'sd8192;
  assign ov_r   = TW'($signed(ov_rnd[32:14]));
  assign amp_s  = $signed({20'd0, amp_r});

  logic [AW+14:0] amp_next;
  assign amp_next = (AW+15)'(amp_r) * (AW+15)'(persistence);

  // divider setup
  logic [ACCW-1:0] acc_mag;
  assign acc_mag = acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);

  // final saturation
  logic [15:0] q_sat;
  assign q_sat = (quo_r > 16'd16384) ? 16'd16384 : quo_r;

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        neg_x_r   <= coord_x[31];
        neg_y_r   <= coord_y[31];
        mag_x_r   <= coord_x[31] ? (32'd0 - coord_x) : coord_x;
        mag_y_r   <= coord_y[31] ? (32'd0 - coord_y) : coord_y;
        acc_r     <= '0;
        amp_r     <= AW'({base_amplitude, 8'd0});
        amp_sum_r <= '0;
      end
      OP_SCALE: prod_r <= sc_prod;
      OP_SPLIT: begin
        if (cmd.sel[0]) begin
          cell_y_r <= cell_s;
          idx_y_r  <= total[39 -: TB];
        end else begin
          cell_x_r <= cell_s;
          idx_x_r  <= total[39 -: TB];
        end
      end
      OP_WLOOK: begin
        wx_r <= wtab[idx_x_r];
        wy_r <= wtab[idx_y_r];
      end
      OP_HPRE: n_r <= hn;
      OP_HSQ:  t_r <= 32'(n_r * n_r);
      OP_HLIN: t_r <= 32'(t_r * HASH_MUL_A) + HASH_ADD_A;
      OP_HFIN: corner_r[cmd.sel] <= hcorner;
      OP_BL1:  mul_a_r <= bl_a_w * bl_wi;
      OP_BL2: begin
        if (cmd.sel == 2'd1) blend_r[1] <= bl_rnd[45:14];
        else                 blend_r[0] <= bl_rnd[45:14];
      end
      OP_ACC1: term_r <= amp_s * ov_r;
      OP_ACC2: begin
        acc_r     <= acc_r + ACCW'(term_r);
        amp_sum_r <= amp_sum_r + SUMW'(amp_r);
        amp_r     <= amp_next[AW+13:14];
      end
      OP_DINIT: begin
        neg_res_r <= acc_r[ACCW-1];
        zero_r    <= (amp_sum_r == '0);
        rem_r     <= DW'(acc_mag) + (DW'(amp_sum_r) << 1);
        dsh_r     <= DW'(amp_sum_r) << 17;
        quo_r     <= '0;
      end
      OP_DSTEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          quo_r <= {quo_r[14:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_FIN: begin
        if (zero_r)         out_height_r <= '0;
        else if (neg_res_r) out_height_r <= $signed(16'd0 - q_sat);
        else                out_height_r <= $signed(q_sat);
      end
      default: ;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (cmd.op == OP_FIN);
  end

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;

endmodule

`default_nettype wire
